/* rtl/core/qrs_pkg.sv */
`default_nettype none

package qrs_pkg;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_ONE_REAL = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_DEGEN    = 2'd3
  } root_kind_t;

  localparam logic [63:0] Q16_POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] Q16_NEG_MAX = 64'h0000_0000_8000_0000;
  localparam int unsigned FRAC_SHIFT  = 16;
  localparam int unsigned SQRT_SHIFT  = 32;

endpackage

`default_nettype wire

/* rtl/core/qrs_coef_if.sv */
`default_nettype none

interface qrs_coef_if #(
  parameter int unsigned COEF_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [COEF_WIDTH-1:0] coef_a;
  logic [COEF_WIDTH-1:0] coef_b;
  logic [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

`default_nettype wire

/* rtl/core/qrs_root_if.sv */
`default_nettype none

interface qrs_root_if;
  logic        valid;
  logic        ready;
  logic [1:0]  root_kind;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic        saturated;

  modport source (output valid, output root_kind, output first_value,
                  output second_value, output saturated, input ready);
  modport sink   (input valid, input root_kind, input first_value,
                  input second_value, input saturated, output ready);
endinterface

`default_nettype wire

/* rtl/core/quadratic_root_solver.sv */
// Throughput: one beat per cycle while root.ready is high; the rate is set by the
// bit-per-stage square root and divider pipes.
// Each stage holds its beat until the next one frees, bubbles close up under stall.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none

module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst,
  qrs_coef_if.sink         coef,
  qrs_root_if.source       root
);

  localparam int unsigned CW     = COEF_WIDTH;
  localparam int unsigned PW     = 2 * CW;
  localparam int unsigned DW     = 2 * CW + 1;
  localparam int unsigned SW     = CW + 17;
  localparam int unsigned XW     = 2 * SW;
  localparam int unsigned NW     = CW + 19;
  localparam int unsigned ST_SQ  = 3;
  localparam int unsigned ST_NUM = ST_SQ + SW;
  localparam int unsigned ST_DIV = ST_NUM + 1;
  localparam int unsigned ST_OUT = ST_DIV + NW;
  localparam int unsigned NS     = ST_OUT + 1;

  typedef struct packed {
    qrs_pkg::root_kind_t kind;
    logic                an;
    logic                bn;
    logic [CW-1:0]       ua;
    logic [CW-1:0]       ub;
  } side_t;

  logic [NS-1:0] v;
  logic [NS-1:0] adv;
  side_t         sd [NS-1];

  // per-stage advance, rippling back from the output
  assign adv[NS-1] = ~v[NS-1] | root.ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_adv
    assign adv[i] = ~v[i] | adv[i+1];
  end
  assign coef.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= coef.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: magnitudes and signs
  side_t in_sd;
  logic  in_cn;
  always_comb begin
    in_sd.an   = coef.coef_a[CW-1];
    in_sd.bn   = coef.coef_b[CW-1];
    in_cn      = coef.coef_c[CW-1];
    in_sd.ua   = in_sd.an ? (~coef.coef_a + 1'b1) : coef.coef_a;
    in_sd.ub   = in_sd.bn ? (~coef.coef_b + 1'b1) : coef.coef_b;
    in_sd.kind = (in_sd.ua == '0) ? qrs_pkg::KIND_DEGEN : qrs_pkg::KIND_TWO_REAL;
  end

  logic [CW-1:0] s0_uc;
  logic          s0_acopp;
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sd[0]    <= in_sd;
      s0_uc    <= in_cn ? (~coef.coef_c + 1'b1) : coef.coef_c;
      s0_acopp <= in_sd.an ^ in_cn;
    end
  end

  // stage 1: products
  logic [PW-1:0] s1_b2;
  logic [PW-1:0] s1_pac;
  logic          s1_acopp;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sd[1]    <= sd[0];
      s1_b2    <= sd[0].ub * sd[0].ub;
      s1_pac   <= sd[0].ua * s0_uc;
      s1_acopp <= s0_acopp;
    end
  end

  // stage 2: discriminant magnitude and class
  logic [PW+1:0]       fac;
  logic [PW+1:0]       b2x;
  logic [PW+1:0]       mag_c;
  qrs_pkg::root_kind_t kind_c;
  always_comb begin
    fac = {s1_pac, 2'b00};
    b2x = {2'b00, s1_b2};
    if (s1_pac != '0 && s1_acopp) begin
      mag_c  = b2x + fac;
      kind_c = qrs_pkg::KIND_TWO_REAL;
    end else if (fac < b2x) begin
      mag_c  = b2x - fac;
      kind_c = qrs_pkg::KIND_TWO_REAL;
    end else if (b2x < fac) begin
      mag_c  = fac - b2x;
      kind_c = qrs_pkg::KIND_COMPLEX;
    end else begin
      mag_c  = '0;
      kind_c = qrs_pkg::KIND_ONE_REAL;
    end
  end

  side_t s2_next;
  always_comb begin
    s2_next = sd[1];
    if (sd[1].kind != qrs_pkg::KIND_DEGEN) begin
      s2_next.kind = kind_c;
    end
  end

  logic [DW-1:0] s2_mag;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sd[2]  <= s2_next;
      s2_mag <= mag_c[DW-1:0];
    end
  end

  // square root, one result bit a stage
  logic [SW+1:0] sq_rem  [SW];
  logic [SW-1:0] sq_root [SW];
  logic [XW-1:0] sq_x    [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [SW+1:0] rem_p;
    logic [SW-1:0] root_p;
    logic [XW-1:0] x_p;
    logic [SW+3:0] tmp;
    logic [SW+3:0] trial;
    logic [SW+1:0] rem_n;
    logic [SW-1:0] root_n;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = {{(XW-DW-qrs_pkg::SQRT_SHIFT){1'b0}}, s2_mag,
                       {qrs_pkg::SQRT_SHIFT{1'b0}}};
    end else begin : g_next
      assign rem_p  = sq_rem[k-1];
      assign root_p = sq_root[k-1];
      assign x_p    = sq_x[k-1];
    end
    always_comb begin
      tmp   = {rem_p, x_p[XW-1-2*k -: 2]};
      trial = {2'b00, root_p, 2'b01};
      if (tmp >= trial) begin
        rem_n  = (SW+2)'(tmp - trial);
        root_n = {root_p[SW-2:0], 1'b1};
      end else begin
        rem_n  = tmp[SW+1:0];
        root_n = {root_p[SW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv[ST_SQ+k]) begin
        sd[ST_SQ+k]  <= sd[ST_SQ+k-1];
        sq_rem[k]    <= rem_n;
        sq_root[k]   <= root_n;
        sq_x[k]      <= x_p;
      end
    end
  end

  // numerators, rounding offset folded in
  side_t          nsd;
  logic signed [NW:0] nb;
  logic signed [NW:0] sx;
  logic signed [NW:0] n1;
  logic signed [NW:0] n2;
  logic [NW:0]        m1;
  logic [NW:0]        m2;
  logic [NW-1:0]      uax;
  always_comb begin
    nsd = sd[ST_NUM-1];
    nb  = nsd.bn ? $signed({4'b0000, nsd.ub, {qrs_pkg::FRAC_SHIFT{1'b0}}})
                 : -$signed({4'b0000, nsd.ub, {qrs_pkg::FRAC_SHIFT{1'b0}}});
    sx  = $signed({3'b000, sq_root[SW-1]});
    case (nsd.kind)
      qrs_pkg::KIND_TWO_REAL: begin
        n1 = nb + sx;
        n2 = nb - sx;
      end
      qrs_pkg::KIND_COMPLEX: begin
        n1 = nb;
        n2 = sx;
      end
      default: begin
        n1 = nb;
        n2 = nb;
      end
    endcase
    m1  = n1[NW] ? -n1 : n1;
    m2  = n2[NW] ? -n2 : n2;
    uax = {{(NW-CW){1'b0}}, nsd.ua};
  end

  logic [NW-1:0] num_d1;
  logic [NW-1:0] num_d2;
  logic          num_neg1;
  logic          num_neg2;
  always_ff @(posedge clk) begin
    if (adv[ST_NUM]) begin
      sd[ST_NUM] <= nsd;
      num_d1     <= m1[NW-1:0] + uax;
      num_d2     <= m2[NW-1:0] + uax;
      num_neg1   <= n1[NW];
      num_neg2   <= n2[NW];
    end
  end

  // dividers by 2|a|, one quotient bit a stage
  logic [CW:0]   dv_rem1 [NW];
  logic [CW:0]   dv_rem2 [NW];
  logic [NW-1:0] dv_q1   [NW];
  logic [NW-1:0] dv_q2   [NW];
  logic [NW-1:0] dv_d1   [NW];
  logic [NW-1:0] dv_d2   [NW];
  logic          dv_n1   [NW];
  logic          dv_n2   [NW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [CW:0]   r1_p;
    logic [CW:0]   r2_p;
    logic [NW-1:0] q1_p;
    logic [NW-1:0] q2_p;
    logic [NW-1:0] d1_p;
    logic [NW-1:0] d2_p;
    logic          n1_p;
    logic          n2_p;
    logic [CW+1:0] t1;
    logic [CW+1:0] t2;
    logic [CW+1:0] dvx;
    logic          b1;
    logic          b2;
    if (j == 0) begin : g_first
      assign r1_p = '0;
      assign r2_p = '0;
      assign q1_p = '0;
      assign q2_p = '0;
      assign d1_p = num_d1;
      assign d2_p = num_d2;
      assign n1_p = num_neg1;
      assign n2_p = num_neg2;
    end else begin : g_next
      assign r1_p = dv_rem1[j-1];
      assign r2_p = dv_rem2[j-1];
      assign q1_p = dv_q1[j-1];
      assign q2_p = dv_q2[j-1];
      assign d1_p = dv_d1[j-1];
      assign d2_p = dv_d2[j-1];
      assign n1_p = dv_n1[j-1];
      assign n2_p = dv_n2[j-1];
    end
    always_comb begin
      dvx = {1'b0, sd[ST_DIV+j-1].ua, 1'b0};
      t1  = {r1_p, d1_p[NW-1-j]};
      t2  = {r2_p, d2_p[NW-1-j]};
      b1  = (t1 >= dvx);
      b2  = (t2 >= dvx);
    end
    always_ff @(posedge clk) begin
      if (adv[ST_DIV+j]) begin
        sd[ST_DIV+j] <= sd[ST_DIV+j-1];
        dv_rem1[j]   <= b1 ? (CW+1)'(t1 - dvx) : t1[CW:0];
        dv_rem2[j]   <= b2 ? (CW+1)'(t2 - dvx) : t2[CW:0];
        dv_q1[j]     <= {q1_p[NW-2:0], b1};
        dv_q2[j]     <= {q2_p[NW-2:0], b2};
        dv_d1[j]     <= d1_p;
        dv_d2[j]     <= d2_p;
        dv_n1[j]     <= n1_p;
        dv_n2[j]     <= n2_p;
      end
    end
  end

  // sign, clipping and output register
  side_t       osd;
  logic [63:0] q1x;
  logic [63:0] q2x;
  logic        neg1;
  logic        neg2;
  logic [31:0] val1;
  logic [31:0] val2;
  logic        sat1;
  logic        sat2;
  always_comb begin
    osd  = sd[ST_OUT-1];
    q1x  = 64'(dv_q1[NW-1]);
    q2x  = 64'(dv_q2[NW-1]);
    neg1 = (dv_n1[NW-1] != osd.an) && (q1x != '0);
    neg2 = (dv_n2[NW-1] != osd.an) && (q2x != '0);
    sat1 = neg1 ? (q1x > qrs_pkg::Q16_NEG_MAX) : (q1x > qrs_pkg::Q16_POS_MAX);
    sat2 = neg2 ? (q2x > qrs_pkg::Q16_NEG_MAX) : (q2x > qrs_pkg::Q16_POS_MAX);
    if (sat1) begin
      val1 = neg1 ? qrs_pkg::Q16_NEG_MAX[31:0] : qrs_pkg::Q16_POS_MAX[31:0];
    end else begin
      val1 = neg1 ? (32'd0 - q1x[31:0]) : q1x[31:0];
    end
    if (sat2) begin
      val2 = neg2 ? qrs_pkg::Q16_NEG_MAX[31:0] : qrs_pkg::Q16_POS_MAX[31:0];
    end else begin
      val2 = neg2 ? (32'd0 - q2x[31:0]) : q2x[31:0];
    end
  end

  logic [1:0]  o_kind;
  logic [31:0] o_first;
  logic [31:0] o_second;
  logic        o_sat;
  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      o_kind <= osd.kind;
      if (osd.kind == qrs_pkg::KIND_DEGEN) begin
        o_first  <= '0;
        o_second <= '0;
        o_sat    <= 1'b0;
      end else begin
        o_first  <= val1;
        o_second <= val2;
        o_sat    <= sat1 | sat2;
      end
    end
  end

  assign root.valid        = v[NS-1];
  assign root.root_kind    = o_kind;
  assign root.first_value  = o_first;
  assign root.second_value = o_second;
  assign root.saturated    = o_sat;

endmodule

`default_nettype wire
